// ===== design/glpu_pkg.sv =====
// Shared types and constants for the Gaussian line profile unit.
`default_nettype none

package glpu_pkg;

   localparam int EXP_TABLE_DEPTH_DEF = 256;

   // sqrt(2*pi) in Q.30
   localparam logic [31:0] SQRT_2PI_Q30 = 32'd2691471616;

   // quotient bits of |u| kept before the exp cutoff, and of the final divide
   localparam int U_BITS = 19;
   localparam int Q_BITS = 48;

   typedef enum logic [1:0] {
      FUNC_PROFILE = 2'd0,
      FUNC_FLUX    = 2'd1,
      FUNC_DZ      = 2'd2,
      FUNC_DSIGMA  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_SIGMA = 2'd1,
      ST_SATURATED  = 2'd2
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [31:0]        sample_wavelength;
      logic [31:0]        line_center;
      logic [31:0]        line_width;
      logic signed [31:0] amplitude;
      logic [31:0]        rest_wavelength;
      logic [23:0]        redshift;
   } req_type;

   typedef struct packed {
      logic signed [47:0] value;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/gaussian_line_profile_unit.sv =====
// Gaussian line profile unit: pipelined profile, flux and derivative evaluator.
// Throughput: one beat per cycle while req_stall is low; two bit-per-stage dividers
// (19 and 48 stages), a two-port exp ROM stage and 32x32-class multipliers set the depth.
// Stalls: a skid register behind the output register holds one result; req_stall
// is high only while it is full. Synchronous reset clears all valid bits.
`default_nettype none

module gaussian_line_profile_unit #(
   parameter int EXP_TABLE_DEPTH = glpu_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire glpu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output glpu_pkg::rsp_type      rsp_data
);
   import glpu_pkg::*;

   localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int PW = 20 + AW;
   localparam int NW = 53;

   typedef logic [31:0] exp_rom_type [0:EXP_TABLE_DEPTH];

   // Taylor terms of exp(-16/D) in Q.48, each floored
   localparam logic [63:0] DW   = 64'(EXP_TABLE_DEPTH);
   localparam logic [63:0] TT1  = (64'd1 << 52) / DW;
   localparam logic [63:0] TT2  = (TT1 * 64'd16) / (DW * 64'd2);
   localparam logic [63:0] TT3  = (TT2 * 64'd16) / (DW * 64'd3);
   localparam logic [63:0] TT4  = (TT3 * 64'd16) / (DW * 64'd4);
   localparam logic [63:0] TT5  = (TT4 * 64'd16) / (DW * 64'd5);
   localparam logic [63:0] TT6  = (TT5 * 64'd16) / (DW * 64'd6);
   localparam logic [63:0] TT7  = (TT6 * 64'd16) / (DW * 64'd7);
   localparam logic [63:0] TT8  = (TT7 * 64'd16) / (DW * 64'd8);
   localparam logic [63:0] TT9  = (TT8 * 64'd16) / (DW * 64'd9);
   localparam logic [63:0] TT10 = (TT9 * 64'd16) / (DW * 64'd10);
   localparam logic [63:0] TT11 = (TT10 * 64'd16) / (DW * 64'd11);
   localparam logic [63:0] TT12 = (TT11 * 64'd16) / (DW * 64'd12);
   localparam logic [63:0] TT13 = (TT12 * 64'd16) / (DW * 64'd13);
   localparam logic [63:0] TT14 = (TT13 * 64'd16) / (DW * 64'd14);
   localparam logic [63:0] TT15 = (TT14 * 64'd16) / (DW * 64'd15);
   localparam logic [63:0] TAYLOR_SUM = (64'd1 << 48) - TT1 + TT2 - TT3 + TT4 - TT5
                                        + TT6 - TT7 + TT8 - TT9 + TT10 - TT11 + TT12
                                        - TT13 + TT14 - TT15;
   localparam logic [63:0] R_STEP = (TAYLOR_SUM + (64'd1 << 16)) >> 17;

   // exp(-16k/D) in Q1.31, each entry stepped from the last by a fixed ratio
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] prev;
      prev = 64'd1 << 31;
      rom[0] = prev[31:0];
      for (int n = 1; n <= EXP_TABLE_DEPTH; n++) begin
         prev   = (prev * R_STEP + (64'd1 << 30)) >> 31;
         rom[n] = prev[31:0];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

   function automatic rsp_type sat_mag(input logic neg, input logic [54:0] mag);
      rsp_type     res;
      logic [54:0] lim;
      logic [47:0] m;
      lim = neg ? (55'd1 << 47) : ((55'd1 << 47) - 55'd1);
      m = mag[47:0];
      res.status = ST_OK;
      if (mag > lim) begin
         m = lim[47:0];
         res.status = ST_SATURATED;
      end
      res.value = $signed(neg ? (48'd0 - m) : m);
      return res;
   endfunction

   // fields that ride along from the first divider to the result select
   typedef struct packed {
      func_type    func;
      logic [31:0] sig;
      logic        neg;
      logic [53:0] fv;
   } carry_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] x;
      logic [31:0] cin;
      logic [31:0] sig;
      logic [31:0] lam;
      logic        amp_neg;
      logic [56:0] cz_prod;
      logic [63:0] fl_prod;
   } s1_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] x;
      logic [31:0] sig;
      logic [31:0] lam;
      logic        amp_neg;
      logic [36:0] c;
      logic [63:0] fl_lo;
      logic [63:0] fl_hp;
   } s2_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] sig;
      logic [31:0] lam;
      logic        neg;
      logic [36:0] dm;
      logic [63:0] fl_hi;
   } s3_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic              big;
      logic [50:0]       rem;
      logic [U_BITS-1:0] q;
   } d1_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic              big;
      logic [U_BITS-1:0] um;
      logic [37:0]       sq;
   } e1_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic [U_BITS-1:0] um;
      logic [37:0]       sq;
      logic              ez;
      logic [PW-1:0]     p;
   } e2_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic [U_BITS-1:0] um;
      logic [37:0]       sq;
      logic              ez;
      logic [31:0]       a;
      logic [31:0]       b;
      logic [15:0]       frac;
   } e3_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic [U_BITS-1:0] um;
      logic [37:0]       sq;
      logic              ez;
      logic [31:0]       a;
      logic [47:0]       dprod;
   } e4_type;

   typedef struct packed {
      carry_type         cy;
      logic [31:0]       lam;
      logic [U_BITS-1:0] um;
      logic [37:0]       sq;
      logic [31:0]       e;
   } e5_type;

   typedef struct packed {
      carry_type   cy;
      logic [31:0] lam;
      logic [37:0] sq;
      logic [16:0] v0;
      logic [50:0] ug;
      logic [24:0] e24;
   } p1_type;

   typedef struct packed {
      carry_type   cy;
      logic [31:0] lam;
      logic [16:0] v0;
      logic [27:0] g;
      logic [62:0] p3;
   } p2_type;

   typedef struct packed {
      carry_type   cy;
      logic [16:0] v0;
      logic [59:0] n2raw;
      logic [30:0] h;
   } p3_type;

   typedef struct packed {
      carry_type     cy;
      logic [16:0]   v0;
      logic [NW-1:0] num;
   } p4_type;

   typedef struct packed {
      carry_type         cy;
      logic [16:0]       v0;
      logic              over;
      logic [NW-1:0]     rem;
      logic [Q_BITS-1:0] q;
   } d2_type;

   logic en;

   req_type s0_ff;
   logic    s0_v_ff;
   s1_type  s1_ff, s1_in;
   logic    s1_v_ff;
   s2_type  s2_ff, s2_in;
   logic    s2_v_ff;
   s3_type  s3_ff, s3_in;
   logic    s3_v_ff;
   d1_type  d1_ff [0:U_BITS];
   d1_type  d1_in [0:U_BITS];
   logic    d1_v_ff [0:U_BITS];
   e1_type  e1_ff, e1_in;
   logic    e1_v_ff;
   e2_type  e2_ff, e2_in;
   logic    e2_v_ff;
   e3_type  e3_ff, e3_in;
   logic    e3_v_ff;
   e4_type  e4_ff, e4_in;
   logic    e4_v_ff;
   e5_type  e5_ff, e5_in;
   logic    e5_v_ff;
   p1_type  p1_ff, p1_in;
   logic    p1_v_ff;
   p2_type  p2_ff, p2_in;
   logic    p2_v_ff;
   p3_type  p3_ff, p3_in;
   logic    p3_v_ff;
   p4_type  p4_ff, p4_in;
   logic    p4_v_ff;
   d2_type  d2_ff [0:Q_BITS];
   d2_type  d2_in [0:Q_BITS];
   logic    d2_v_ff [0:Q_BITS];
   rsp_type fin_ff, fin_in;
   logic    fin_v_ff;

   rsp_type out_ff, out_in;
   logic    out_v_ff, out_v_in;
   rsp_type skid_ff, skid_in;
   logic    skid_full_ff, skid_full_in;
   logic    take;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // ---- stage 0: input register
   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else if (en) s0_v_ff <= req_valid;
      if (en) s0_ff <= req_data;
   end

   // ---- stage 1: center product and |A|*sigma
   always_comb begin
      logic [31:0] am;
      logic [24:0] zs;
      am = s0_ff.amplitude[31] ? (32'd0 - s0_ff.amplitude) : s0_ff.amplitude;
      zs = (25'd1 << 20) + 25'(s0_ff.redshift);
      s1_in.func    = s0_ff.func;
      s1_in.x       = s0_ff.sample_wavelength;
      s1_in.cin     = s0_ff.line_center;
      s1_in.sig     = s0_ff.line_width;
      s1_in.lam     = s0_ff.rest_wavelength;
      s1_in.amp_neg = s0_ff.amplitude[31];
      s1_in.cz_prod = 57'(s0_ff.rest_wavelength) * 57'(zs);
      s1_in.fl_prod = 64'(am) * 64'(s0_ff.line_width);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= s0_v_ff;
      if (en) s1_ff <= s1_in;
   end

   // ---- stage 2: rounded shifted center, flux times sqrt(2 pi) partials
   always_comb begin
      logic [57:0] cr;
      cr = {1'b0, s1_ff.cz_prod} + (58'd1 << 19);
      s2_in.func    = s1_ff.func;
      s2_in.x       = s1_ff.x;
      s2_in.sig     = s1_ff.sig;
      s2_in.lam     = s1_ff.lam;
      s2_in.amp_neg = s1_ff.amp_neg;
      s2_in.c       = (s1_ff.func == FUNC_DZ) ? cr[56:20] : 37'(s1_ff.cin);
      s2_in.fl_lo   = 64'(s1_ff.fl_prod[31:0]) * 64'(SQRT_2PI_Q30);
      s2_in.fl_hp   = 64'(s1_ff.fl_prod[63:32]) * 64'(SQRT_2PI_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
      if (en) s2_ff <= s2_in;
   end

   // ---- stage 3: |x - center| and its sign, or the amplitude sign for flux
   always_comb begin
      logic        lt;
      logic [36:0] xw;
      xw = 37'(s2_ff.x);
      lt = xw < s2_ff.c;
      s3_in.func  = s2_ff.func;
      s3_in.sig   = s2_ff.sig;
      s3_in.lam   = s2_ff.lam;
      s3_in.neg   = (s2_ff.func == FUNC_FLUX) ? s2_ff.amp_neg : lt;
      s3_in.dm    = lt ? (s2_ff.c - xw) : (xw - s2_ff.c);
      s3_in.fl_hi = s2_ff.fl_hp + {32'd0, s2_ff.fl_lo[63:32]};
   end

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (en) s3_v_ff <= s2_v_ff;
      if (en) s3_ff <= s3_in;
   end

   // ---- stage 4: divider entry; |u| >= 8 is past the exp cutoff
   always_comb begin
      logic [63:0] fr;
      fr = s3_ff.fl_hi + 64'd512;
      d1_in[0].cy.func = s3_ff.func;
      d1_in[0].cy.sig  = s3_ff.sig;
      d1_in[0].cy.neg  = s3_ff.neg;
      d1_in[0].cy.fv   = fr[63:10];
      d1_in[0].lam     = s3_ff.lam;
      d1_in[0].big     = s3_ff.dm >= {2'b00, s3_ff.sig, 3'b000};
      d1_in[0].rem     = {s3_ff.dm[34:0], 16'd0};
      d1_in[0].q       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) d1_v_ff[0] <= 1'b0;
      else if (en) d1_v_ff[0] <= s3_v_ff;
      if (en) d1_ff[0] <= d1_in[0];
   end

   // ---- |u| = (dm << 16) / sigma, one quotient bit per stage
   for (genvar k = 0; k < U_BITS; k++) begin : g_div_u
      localparam int BIT = U_BITS - 1 - k;

      always_comb begin
         logic [50:0] trial;
         trial = 51'(d1_ff[k].cy.sig) << BIT;
         d1_in[k+1] = d1_ff[k];
         if (d1_ff[k].rem >= trial) begin
            d1_in[k+1].rem    = d1_ff[k].rem - trial;
            d1_in[k+1].q[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) d1_v_ff[k+1] <= 1'b0;
         else if (en) d1_v_ff[k+1] <= d1_v_ff[k];
         if (en) d1_ff[k+1] <= d1_in[k+1];
      end
   end

   // ---- exp stage 1: u squared
   always_comb begin
      e1_in.cy  = d1_ff[U_BITS].cy;
      e1_in.lam = d1_ff[U_BITS].lam;
      e1_in.big = d1_ff[U_BITS].big;
      e1_in.um  = d1_ff[U_BITS].q;
      e1_in.sq  = 38'(d1_ff[U_BITS].q) * 38'(d1_ff[U_BITS].q);
   end

   always_ff @(posedge clock) begin
      if (reset) e1_v_ff <= 1'b0;
      else if (en) e1_v_ff <= d1_v_ff[U_BITS];
      if (en) e1_ff <= e1_in;
   end

   // ---- exp stage 2: t = u^2/2, scaled onto the table grid
   always_comb begin
      logic [20:0] t;
      t = e1_ff.sq[37:17];
      e2_in.cy  = e1_ff.cy;
      e2_in.lam = e1_ff.lam;
      e2_in.um  = e1_ff.um;
      e2_in.sq  = e1_ff.sq;
      e2_in.ez  = e1_ff.big || t[20];
      e2_in.p   = PW'(t[19:0]) * PW'(EXP_TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) e2_v_ff <= 1'b0;
      else if (en) e2_v_ff <= e1_v_ff;
      if (en) e2_ff <= e2_in;
   end

   // ---- exp stage 3: table read at the two neighboring points
   always_comb begin
      logic [AW-1:0] idx;
      idx = e2_ff.p[PW-1:20];
      e3_in.cy   = e2_ff.cy;
      e3_in.lam  = e2_ff.lam;
      e3_in.um   = e2_ff.um;
      e3_in.sq   = e2_ff.sq;
      e3_in.ez   = e2_ff.ez;
      e3_in.a    = EXP_ROM[idx];
      e3_in.b    = EXP_ROM[AW'(idx + 1'b1)];
      e3_in.frac = e2_ff.p[19:4];
   end

   always_ff @(posedge clock) begin
      if (reset) e3_v_ff <= 1'b0;
      else if (en) e3_v_ff <= e2_v_ff;
      if (en) e3_ff <= e3_in;
   end

   // ---- exp stage 4: interpolation product
   always_comb begin
      e4_in.cy    = e3_ff.cy;
      e4_in.lam   = e3_ff.lam;
      e4_in.um    = e3_ff.um;
      e4_in.sq    = e3_ff.sq;
      e4_in.ez    = e3_ff.ez;
      e4_in.a     = e3_ff.a;
      e4_in.dprod = 48'(e3_ff.a - e3_ff.b) * 48'(e3_ff.frac);
   end

   always_ff @(posedge clock) begin
      if (reset) e4_v_ff <= 1'b0;
      else if (en) e4_v_ff <= e3_v_ff;
      if (en) e4_ff <= e4_in;
   end

   // ---- exp stage 5: e in Q.31
   always_comb begin
      logic [47:0] rnd;
      rnd = e4_ff.dprod + 48'h8000;
      e5_in.cy  = e4_ff.cy;
      e5_in.lam = e4_ff.lam;
      e5_in.um  = e4_ff.um;
      e5_in.sq  = e4_ff.sq;
      e5_in.e   = e4_ff.ez ? 32'd0 : (e4_ff.a - rnd[47:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) e5_v_ff <= 1'b0;
      else if (en) e5_v_ff <= e4_v_ff;
      if (en) e5_ff <= e5_in;
   end

   // ---- post 1: profile value, u*e, e rounded to Q.24
   always_comb begin
      logic [32:0] r0;
      logic [32:0] r24;
      r0  = 33'(e5_ff.e) + (33'd1 << 14);
      r24 = 33'(e5_ff.e) + 33'd64;
      p1_in.cy  = e5_ff.cy;
      p1_in.lam = e5_ff.lam;
      p1_in.sq  = e5_ff.sq;
      p1_in.v0  = r0[31:15];
      p1_in.ug  = 51'(e5_ff.um) * 51'(e5_ff.e);
      p1_in.e24 = r24[31:7];
   end

   always_ff @(posedge clock) begin
      if (reset) p1_v_ff <= 1'b0;
      else if (en) p1_v_ff <= e5_v_ff;
      if (en) p1_ff <= p1_in;
   end

   // ---- post 2: g in Q.24, u^2 * e24
   always_comb begin
      logic [50:0] gr;
      gr = p1_ff.ug + (51'd1 << 22);
      p2_in.cy  = p1_ff.cy;
      p2_in.lam = p1_ff.lam;
      p2_in.v0  = p1_ff.v0;
      p2_in.g   = gr[50:23];
      p2_in.p3  = 63'(p1_ff.sq) * 63'(p1_ff.e24);
   end

   always_ff @(posedge clock) begin
      if (reset) p2_v_ff <= 1'b0;
      else if (en) p2_v_ff <= p1_v_ff;
      if (en) p2_ff <= p2_in;
   end

   // ---- post 3: lambda0 * g, h in Q.24
   always_comb begin
      logic [62:0] hr;
      hr = p2_ff.p3 + (63'd1 << 31);
      p3_in.cy    = p2_ff.cy;
      p3_in.v0    = p2_ff.v0;
      p3_in.n2raw = 60'(p2_ff.lam) * 60'(p2_ff.g);
      p3_in.h     = hr[62:32];
   end

   always_ff @(posedge clock) begin
      if (reset) p3_v_ff <= 1'b0;
      else if (en) p3_v_ff <= p2_v_ff;
      if (en) p3_ff <= p3_in;
   end

   // ---- post 4: dividend of the final divide, rounding folded in
   always_comb begin
      logic [60:0] n2;
      logic [35:0] n3;
      n2 = 61'(p3_ff.n2raw) + 61'({p3_ff.cy.sig, 7'd0});
      n3 = 36'({p3_ff.h, 4'd0}) + 36'(p3_ff.cy.sig[31:1]);
      p4_in.cy  = p3_ff.cy;
      p4_in.v0  = p3_ff.v0;
      p4_in.num = (p3_ff.cy.func == FUNC_DZ) ? n2[60:8] : NW'(n3);
   end

   always_ff @(posedge clock) begin
      if (reset) p4_v_ff <= 1'b0;
      else if (en) p4_v_ff <= p3_v_ff;
      if (en) p4_ff <= p4_in;
   end

   // ---- final divider entry: quotient of 2^48 or more saturates anyway
   always_comb begin
      d2_in[0].cy   = p4_ff.cy;
      d2_in[0].v0   = p4_ff.v0;
      d2_in[0].over = (80'(p4_ff.num) >= (80'(p4_ff.cy.sig) << Q_BITS));
      d2_in[0].rem  = p4_ff.num;
      d2_in[0].q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) d2_v_ff[0] <= 1'b0;
      else if (en) d2_v_ff[0] <= p4_v_ff;
      if (en) d2_ff[0] <= d2_in[0];
   end

   for (genvar k = 0; k < Q_BITS; k++) begin : g_div_q
      localparam int BIT = Q_BITS - 1 - k;

      always_comb begin
         logic [79:0] trial;
         trial = 80'(d2_ff[k].cy.sig) << BIT;
         d2_in[k+1] = d2_ff[k];
         if (80'(d2_ff[k].rem) >= trial) begin
            d2_in[k+1].rem    = d2_ff[k].rem - trial[NW-1:0];
            d2_in[k+1].q[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) d2_v_ff[k+1] <= 1'b0;
         else if (en) d2_v_ff[k+1] <= d2_v_ff[k];
         if (en) d2_ff[k+1] <= d2_in[k+1];
      end
   end

   // ---- result select and saturation
   always_comb begin
      d2_type      d;
      logic [54:0] qm;
      d  = d2_ff[Q_BITS];
      qm = d.over ? '1 : 55'(d.q);
      fin_in.value  = '0;
      fin_in.status = ST_OK;
      case (d.cy.func)
         FUNC_PROFILE: fin_in.value = 48'(d.v0);
         FUNC_FLUX:    fin_in = sat_mag(d.cy.neg, 55'(d.cy.fv));
         FUNC_DZ:      fin_in = sat_mag(d.cy.neg && (d.over || d.q != '0), qm);
         default:      fin_in = sat_mag(1'b0, qm);
      endcase
      if (d.cy.sig == '0 && d.cy.func != FUNC_FLUX) begin
         fin_in.value  = '0;
         fin_in.status = ST_ZERO_SIGMA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fin_v_ff <= 1'b0;
      else if (en) fin_v_ff <= d2_v_ff[Q_BITS];
      if (en) fin_ff <= fin_in;
   end

   // ---- output register plus skid
   always_comb begin
      take         = out_v_ff && !rsp_stall;
      out_in       = out_ff;
      out_v_in     = out_v_ff;
      skid_in      = skid_ff;
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (take) begin
            out_in       = skid_ff;
            skid_full_in = 1'b0;
         end
      end else if (fin_v_ff) begin
         if (!out_v_ff || take) begin
            out_in   = fin_ff;
            out_v_in = 1'b1;
         end else begin
            skid_in      = fin_ff;
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff     <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_v_ff     <= out_v_in;
         skid_full_ff <= skid_full_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // ---- checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_v_ff)
      else $error("skid holds a beat while output is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_zero_sigma_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_ZERO_SIGMA) |-> (rsp_data.value == '0))
      else $error("zero sigma beat carries a nonzero value");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_SATURATED) |->
         (rsp_data.value == 48'sh7FFF_FFFF_FFFF || rsp_data.value == 48'sh8000_0000_0000))
      else $error("saturated beat not at a range limit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != 2'd3))
      else $error("unused status code on output");

endmodule

`default_nettype wire

// ===== tb/gaussian_line_profile_unit_test.sv =====
// Testbench for the Gaussian line profile unit: random and directed beats against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module gaussian_line_profile_unit_test;
   import glpu_pkg::*;

   localparam int TABLE_DEPTH = EXP_TABLE_DEPTH_DEF;
   localparam int LATENCY = 83;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF;

   // Golden prediction of one beat
   class line_profile_scoreboard;
      rsp_type expected_q[$];
      logic [63:0] exp_points[TABLE_DEPTH + 1];
      int errors;

      function new();
         logic [63:0] sum, term, step;
         errors = 0;
         sum = 64'd1 << 48;
         term = 64'd1 << 48;
         for (int n = 1; n <= 15; n++) begin
            term = (term * 16) / (64'(TABLE_DEPTH) * 64'(n));
            if (n & 1) sum = sum - term;
            else sum = sum + term;
         end
         step = (sum + (64'd1 << 16)) >> 17;
         exp_points[0] = 64'd1 << 31;
         for (int n = 1; n <= TABLE_DEPTH; n++)
            exp_points[n] = (exp_points[n-1] * step + (64'd1 << 30)) >> 31;
      endfunction

      function logic [63:0] gauss_exp(logic [63:0] um);
         logic [63:0] t, p, idx, frac, a, b;
         if (um >= (64'd1 << 19)) return 0;
         t = (um * um) >> 17;
         if (t >= (64'd16 << 16)) return 0;
         p = t * TABLE_DEPTH;
         idx = p >> 20;
         frac = (p >> 4) & 64'hFFFF;
         if (idx >= TABLE_DEPTH) return 0;
         a = exp_points[idx];
         b = exp_points[idx + 1];
         return a - (((a - b) * frac + 64'h8000) >> 16);
      endfunction

      function logic [47:0] clamp(bit neg, logic [63:0] mag, ref status_type st);
         if (!neg && mag > MAX_POS) begin
            st = ST_SATURATED;
            mag = MAX_POS;
         end
         if (neg && mag > MAX_POS + 1) begin
            st = ST_SATURATED;
            mag = MAX_POS + 1;
         end
         return neg ? 48'(64'd0 - mag) : 48'(mag);
      endfunction

      function void note_request(req_type r);
         rsp_type res;
         logic [63:0] x, c, sig, lam, am, mag, hi, lo, dm, um, e, g, den, e24, h;
         bit neg;
         status_type st;
         st = ST_OK;
         res.value = '0;
         x = r.sample_wavelength;
         c = r.line_center;
         sig = r.line_width;
         lam = r.rest_wavelength;
         if (r.func == FUNC_FLUX) begin
            neg = r.amplitude[31];
            am = neg ? (64'd1 << 32) - 64'(r.amplitude[31:0]) : 64'(r.amplitude[31:0]);
            mag = am * sig;
            lo = (mag & 64'hFFFF_FFFF) * SQRT_2PI_Q30;
            hi = (mag >> 32) * SQRT_2PI_Q30 + (lo >> 32);
            res.value = clamp(neg, (hi + 512) >> 10, st);
         end else if (sig == 0) begin
            st = ST_ZERO_SIGMA;
         end else begin
            if (r.func == FUNC_DZ)
               c = (lam * ((64'd1 << 20) + 64'(r.redshift)) + (64'd1 << 19)) >> 20;
            neg = x < c;
            dm = neg ? c - x : x - c;
            um = (dm << 16) / sig;
            e = gauss_exp(um);
            if (r.func == FUNC_PROFILE) begin
               res.value = 48'((e + (64'd1 << 14)) >> 15);
            end else if (r.func == FUNC_DZ) begin
               g = (um * e + (64'd1 << 22)) >> 23;
               den = sig << 8;
               mag = (lam * g + den / 2) / den;
               res.value = clamp(neg && mag != 0, mag, st);
            end else begin
               e24 = (e + 64) >> 7;
               h = (um * um * e24 + (64'd1 << 31)) >> 32;
               res.value = clamp(0, ((h << 4) + sig / 2) / sig, st);
            end
         end
         res.status = st;
         expected_q.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", $time, got.value,
                     got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;

   line_profile_scoreboard board = new();
   longint cycle_count = 0;
   bit quiet_tail = 0;
   bit long_hold = 0;
   int hold_len = 0;

   gaussian_line_profile_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Receiver stalls: random bursts, one long hold on request
   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1;
         hold_len <= hold_len + 1;
      end else if (quiet_tail) begin
         rsp_stall <= 0;
      end else if (hold_len > 0) begin
         hold_len <= hold_len - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 7) == 0) begin
         hold_len <= $urandom_range(0, 9);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   // Mostly near-center samples so the exp table is exercised
   function automatic req_type random_request();
      req_type r;
      logic [31:0] spread;
      r.func = func_type'($urandom_range(0, 3));
      r.line_center = $urandom;
      r.line_width = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(1, 32'h000F_FFFF);
      r.amplitude = $urandom;
      r.rest_wavelength = $urandom;
      r.redshift = $urandom;
      if ($urandom_range(0, 4) != 0) begin
         spread = r.line_width * $urandom_range(0, 9);
         r.sample_wavelength = $urandom_range(0, 1) ? r.line_center + $urandom_range(0, spread)
                                                    : r.line_center - $urandom_range(0, spread);
         if (r.func == FUNC_DZ) begin
            r.rest_wavelength = $urandom_range(0, 32'h0FFF_FFFF);
            r.sample_wavelength = 32'((64'(r.rest_wavelength) * ((64'd1 << 20)
                                  + 64'(r.redshift))) >> 20) + $urandom_range(0, spread);
         end
      end else begin
         r.sample_wavelength = pick32();
      end
      return r;
   endfunction

   task automatic send_beat(req_type r, bit allow_gaps);
      int gap;
      if (allow_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic directed_part();
      req_type r;
      func_type f;
      f = FUNC_PROFILE;
      for (int k = 0; k < 4; k++) begin
         r = '0;
         r.func = f;
         r.line_width = 0;
         r.sample_wavelength = 32'hFFFF_FFFF;
         send_beat(r, 0);                      // zero sigma
         r.line_width = 32'h1000;
         r.line_center = 32'h10_0000;
         r.sample_wavelength = 32'h10_0000;
         r.rest_wavelength = 32'h10_0000;
         send_beat(r, 0);                      // at center
         r.sample_wavelength = 32'h10_1800;
         r.amplitude = 32'sh8000_0000;
         r.redshift = 24'hFFFFFF;
         send_beat(r, 0);
         r.sample_wavelength = 32'hFFFF_FFFF;   // far off center
         r.line_width = 1;
         r.amplitude = 32'sh7FFF_FFFF;
         r.rest_wavelength = 32'hFFFF_FFFF;
         send_beat(r, 0);
         r.line_width = 32'hFFFF_FFFF;
         r.sample_wavelength = 0;
         r.line_center = 32'hFFFF_FFFF;
         send_beat(r, 0);
         f = func_type'(f + 1);
      end
      // redshift derivative at the shifted center: tiny sigma, huge lambda0
      r = '0;
      r.func = FUNC_DZ;
      r.rest_wavelength = 32'hFFFF_FFFF;
      r.line_width = 1;
      r.sample_wavelength = 32'hFFFF_FFFF;
      r.redshift = 0;
      send_beat(r, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      directed_part();
      for (int n = 0; n < 1330; n++) begin
         if (n == 300) begin
            long_hold <= 1;
            fork
               begin
                  while (hold_len < 200) @(negedge clock);
                  long_hold <= 0;
               end
            join_none
         end
         if (n == 600) wait_drained();
         if (n == 1150) quiet_tail <= 1;
         send_beat(random_request(), 1);
      end
      wait_drained();
      repeat (LATENCY + 20) @(negedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
